/* src/rro_pkg.sv */
// ----------------------------------------------------------------------------
// rro_pkg: shared types and constants for the rotated rectangle overlap test
// Fixed-point formats, the quarter-wave sine table and the stage payloads.
// ----------------------------------------------------------------------------
package rro_pkg;

  // field widths
  localparam int COORD_BITS = 20;
  localparam int ANGLE_BITS = 10;
  localparam int EXT_BITS   = 16;

  // quarter-wave table geometry
  localparam int QIDX_BITS = ANGLE_BITS - 2;
  localparam int QN        = 1 << QIDX_BITS;

  // Q14 trig values in [-16384, 16384]
  localparam int TRIG_BITS = 16;
  localparam int TRIG_ONE  = 16384;

  // extent * trig products, rotated offsets (Q15) and their Q1 rounding
  localparam int PROD_BITS = 32;
  localparam int OFF_BITS  = PROD_BITS + 1;
  localparam int RND_SHIFT = 14;
  localparam int RND_BITS  = OFF_BITS - RND_SHIFT;

  // corner coordinates (Q1), differences and cross-product terms
  localparam int CW = ((COORD_BITS + 1 > RND_BITS) ? COORD_BITS + 1 : RND_BITS) + 1;
  localparam int DW = CW + 1;
  localparam int XW = 2 * DW;

  // points tested against one edge: two own far corners, four other corners
  localparam int NPTS  = 6;
  localparam int NEDGE = 8;

  // sine series
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam int SERIES_TERMS = 8;
  localparam logic [63:0] SERIES_DIV [SERIES_TERMS] = '{
    64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  typedef logic signed [TRIG_BITS-1:0] trig_t;
  typedef trig_t sin_tbl_t [QN];

  // Q14 sine of a quarter-wave table index, evaluated at elaboration
  function automatic trig_t quarter_sine(input logic [63:0] q);
    logic [63:0]        theta;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    theta = (PI_HALF_Q30 * q) >> QIDX_BITS;
    t2    = (theta * theta) >> 30;
    term  = theta;
    sum   = signed'(theta);
    for (int k = 1; k < SERIES_TERMS; k++) begin
      term = (term * t2) >> 30;
      term = term / SERIES_DIV[k];
      if (k % 2 == 1) sum = sum - signed'(term);
      else            sum = sum + signed'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd32768) >>> 16;
    if (sum > TRIG_ONE) sum = TRIG_ONE;
    return TRIG_BITS'(sum);
  endfunction

  function automatic sin_tbl_t build_sin_tbl();
    sin_tbl_t t;
    for (int i = 0; i < QN; i++) t[i] = quarter_sine(64'(i));
    return t;
  endfunction

  localparam sin_tbl_t SIN_TBL  = build_sin_tbl();
  localparam trig_t    SIN_PEAK = quarter_sine(64'(QN));

  // one rectangle as it arrives
  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic [EXT_BITS-1:0]          w;
    logic [EXT_BITS-1:0]          h;
    logic [ANGLE_BITS-1:0]        ang;
  } rect_t;

  // rectangle with its sine and cosine
  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic [EXT_BITS-1:0]          w;
    logic [EXT_BITS-1:0]          h;
    trig_t                        sn;
    trig_t                        cs;
  } geo_t;

  // rectangle with its extent products
  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [PROD_BITS-1:0]  wc;
    logic signed [PROD_BITS-1:0]  hs;
    logic signed [PROD_BITS-1:0]  ws;
    logic signed [PROD_BITS-1:0]  hc;
  } prod_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } pt_t;

  typedef pt_t [3:0] quad_t;

  // one edge: direction and the offsets of the tested points
  typedef struct packed {
    logic signed [DW-1:0]             ex;
    logic signed [DW-1:0]             ey;
    logic signed [NPTS-1:0][DW-1:0]   px;
    logic signed [NPTS-1:0][DW-1:0]   py;
  } edge_diff_t;

  // one edge: the two cross-product terms per tested point
  typedef struct packed {
    logic signed [NPTS-1:0][XW-1:0] ta;
    logic signed [NPTS-1:0][XW-1:0] tb;
  } edge_term_t;

endpackage

/* src/rro_if.sv */
// ----------------------------------------------------------------------------
// rro_if: valid/ready channels of the rotated rectangle overlap test
// Input channel carries a pair of rectangles, output channel the verdict.
// ----------------------------------------------------------------------------
interface rro_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rro_pkg::COORD_BITS-1:0] first_center_x;
  logic signed [rro_pkg::COORD_BITS-1:0] first_center_y;
  logic [rro_pkg::EXT_BITS-1:0]          first_width;
  logic [rro_pkg::EXT_BITS-1:0]          first_height;
  logic [rro_pkg::ANGLE_BITS-1:0]        first_angle;
  logic signed [rro_pkg::COORD_BITS-1:0] second_center_x;
  logic signed [rro_pkg::COORD_BITS-1:0] second_center_y;
  logic [rro_pkg::EXT_BITS-1:0]          second_width;
  logic [rro_pkg::EXT_BITS-1:0]          second_height;
  logic [rro_pkg::ANGLE_BITS-1:0]        second_angle;

  modport source (
    output valid, first_center_x, first_center_y, first_width, first_height, first_angle,
           second_center_x, second_center_y, second_width, second_height, second_angle,
    input  ready
  );
  modport sink (
    input  valid, first_center_x, first_center_y, first_width, first_height, first_angle,
           second_center_x, second_center_y, second_width, second_height, second_angle,
    output ready
  );
endinterface

interface rro_out_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink   (input valid, overlap, output ready);
endinterface

/* src/rro_sincos.sv */
// ----------------------------------------------------------------------------
// rro_sincos: sine and cosine lookup stage
// Folds each angle onto the quarter-wave table and registers sin/cos.
// ----------------------------------------------------------------------------
module rro_sincos (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  rro_pkg::rect_t [1:0] rect_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output rro_pkg::geo_t [1:0]  geo_o
);

  // quarter-wave fold: odd quadrants mirror, upper half negates
  function automatic rro_pkg::trig_t sine_lut(input logic [rro_pkg::ANGLE_BITS-1:0] a);
    logic [1:0]                     quad;
    logic [rro_pkg::QIDX_BITS-1:0]  r;
    logic [rro_pkg::QIDX_BITS-1:0]  ri;
    rro_pkg::trig_t                 s;
    quad = a[rro_pkg::ANGLE_BITS-1 -: 2];
    r    = a[rro_pkg::QIDX_BITS-1:0];
    ri   = rro_pkg::QIDX_BITS'(~r + 1'b1);
    if (quad[0]) s = (r == '0) ? rro_pkg::SIN_PEAK : rro_pkg::SIN_TBL[ri];
    else         s = rro_pkg::SIN_TBL[r];
    return quad[1] ? -s : s;
  endfunction

  logic                valid_q;
  rro_pkg::geo_t [1:0] geo_d, geo_q;
  logic                en;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  // table reads for both rectangles
  always_comb begin
    for (int r = 0; r < 2; r++) begin
      geo_d[r].cx = rect_i[r].cx;
      geo_d[r].cy = rect_i[r].cy;
      geo_d[r].w  = rect_i[r].w;
      geo_d[r].h  = rect_i[r].h;
      geo_d[r].sn = sine_lut(rect_i[r].ang);
      geo_d[r].cs = sine_lut(rect_i[r].ang + rro_pkg::ANGLE_BITS'(rro_pkg::QN));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      geo_q <= geo_d;
    end
  end

  assign valid_o = valid_q;
  assign geo_o   = geo_q;

`ifndef NO_ASSERTIONS
  // zero angle gives sine 0 and cosine one
  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o && rect_i[0].ang == '0) |=>
      (geo_q[0].sn == 0 && geo_q[0].cs == rro_pkg::TRIG_BITS'(rro_pkg::TRIG_ONE)))
    else $error("sincos: zero angle lookup wrong");
`endif

endmodule

/* src/rro_corners.sv */
// ----------------------------------------------------------------------------
// rro_corners: corner rotation stages
// Multiplies extents by sin/cos, then rounds offsets to Q1 and adds centers.
// ----------------------------------------------------------------------------
module rro_corners (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  rro_pkg::geo_t [1:0]  geo_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output rro_pkg::quad_t [1:0] quad_o
);

  // corner signs: x negative for corners 2,3; y negative for corners 1,2
  localparam logic [3:0] SX_NEG = 4'b1100;
  localparam logic [3:0] SY_NEG = 4'b0110;

  function automatic logic signed [rro_pkg::OFF_BITS-1:0] signed_sum(
    input logic signed [rro_pkg::PROD_BITS-1:0] a, input logic na,
    input logic signed [rro_pkg::PROD_BITS-1:0] b, input logic nb);
    logic signed [rro_pkg::OFF_BITS-1:0] ea;
    logic signed [rro_pkg::OFF_BITS-1:0] eb;
    ea = na ? -rro_pkg::OFF_BITS'(a) : rro_pkg::OFF_BITS'(a);
    eb = nb ? -rro_pkg::OFF_BITS'(b) : rro_pkg::OFF_BITS'(b);
    return ea + eb;
  endfunction

  // floor((v + 2^13) / 2^14)
  function automatic logic signed [rro_pkg::RND_BITS-1:0] round_q1(
    input logic signed [rro_pkg::OFF_BITS-1:0] v);
    logic signed [rro_pkg::OFF_BITS-1:0] w;
    w = v + rro_pkg::OFF_BITS'(1 << (rro_pkg::RND_SHIFT - 1));
    return w[rro_pkg::OFF_BITS-1:rro_pkg::RND_SHIFT];
  endfunction

  logic                 valid1_q, valid2_q;
  logic                 en1, en2;
  rro_pkg::prod_t [1:0] prod_d, prod_q;
  rro_pkg::quad_t [1:0] quad_d, quad_q;

  assign en2     = !valid2_q || ready_i;
  assign en1     = !valid1_q || en2;
  assign ready_o = en1;

  // extent times trig products
  always_comb begin
    for (int r = 0; r < 2; r++) begin
      prod_d[r].cx = geo_i[r].cx;
      prod_d[r].cy = geo_i[r].cy;
      prod_d[r].wc = rro_pkg::PROD_BITS'(signed'({1'b0, geo_i[r].w}))
                   * rro_pkg::PROD_BITS'(geo_i[r].cs);
      prod_d[r].hs = rro_pkg::PROD_BITS'(signed'({1'b0, geo_i[r].h}))
                   * rro_pkg::PROD_BITS'(geo_i[r].sn);
      prod_d[r].ws = rro_pkg::PROD_BITS'(signed'({1'b0, geo_i[r].w}))
                   * rro_pkg::PROD_BITS'(geo_i[r].sn);
      prod_d[r].hc = rro_pkg::PROD_BITS'(signed'({1'b0, geo_i[r].h}))
                   * rro_pkg::PROD_BITS'(geo_i[r].cs);
    end
  end

  // rotated offsets, rounding and center add
  always_comb begin
    logic signed [rro_pkg::COORD_BITS:0] c2x;
    logic signed [rro_pkg::COORD_BITS:0] c2y;
    for (int r = 0; r < 2; r++) begin
      c2x = {prod_q[r].cx, 1'b0};
      c2y = {prod_q[r].cy, 1'b0};
      for (int i = 0; i < 4; i++) begin
        quad_d[r][i].x = rro_pkg::CW'(c2x) + rro_pkg::CW'(round_q1(
          signed_sum(prod_q[r].wc, SX_NEG[i], prod_q[r].hs, !SY_NEG[i])));
        quad_d[r][i].y = rro_pkg::CW'(c2y) + rro_pkg::CW'(round_q1(
          signed_sum(prod_q[r].ws, SX_NEG[i], prod_q[r].hc, SY_NEG[i])));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      if (en1) valid1_q <= valid_i;
      if (en2) valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i)  prod_q <= prod_d;
    if (en2 && valid1_q) quad_q <= quad_d;
  end

  assign valid_o = valid2_q;
  assign quad_o  = quad_q;

endmodule

/* src/rro_sep.sv */
// ----------------------------------------------------------------------------
// rro_sep: separating-edge test stages
// Edge and point differences, cross-product terms, then sign test and verdict.
// ----------------------------------------------------------------------------
module rro_sep (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  rro_pkg::quad_t [1:0] quad_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic                 overlap_o
);

  logic                                      valid1_q, valid2_q, valid3_q;
  logic                                      en1, en2, en3;
  rro_pkg::edge_diff_t [rro_pkg::NEDGE-1:0]  diff_d, diff_q;
  rro_pkg::edge_term_t [rro_pkg::NEDGE-1:0]  term_d, term_q;
  logic                                      overlap_d, overlap_q;

  assign en3     = !valid3_q || ready_i;
  assign en2     = !valid2_q || en3;
  assign en1     = !valid1_q || en2;
  assign ready_o = en1;

  // differences against the edge start corner
  always_comb begin
    rro_pkg::pt_t a, b;
    rro_pkg::pt_t p [rro_pkg::NPTS];
    logic [1:0]   e1, e2, e3;
    for (int r = 0; r < 2; r++) begin
      for (int e = 0; e < 4; e++) begin
        e1 = 2'(e + 1);
        e2 = 2'(e + 2);
        e3 = 2'(e + 3);
        a  = quad_i[r][e];
        b  = quad_i[r][e1];
        p[0] = quad_i[r][e2];
        p[1] = quad_i[r][e3];
        for (int j = 0; j < 4; j++) p[j+2] = quad_i[1-r][j];
        diff_d[r*4+e].ex = rro_pkg::DW'(b.x) - rro_pkg::DW'(a.x);
        diff_d[r*4+e].ey = rro_pkg::DW'(b.y) - rro_pkg::DW'(a.y);
        for (int j = 0; j < rro_pkg::NPTS; j++) begin
          diff_d[r*4+e].px[j] = rro_pkg::DW'(p[j].x) - rro_pkg::DW'(a.x);
          diff_d[r*4+e].py[j] = rro_pkg::DW'(p[j].y) - rro_pkg::DW'(a.y);
        end
      end
    end
  end

  // cross-product terms: py*ex and ey*px
  always_comb begin
    for (int n = 0; n < rro_pkg::NEDGE; n++) begin
      for (int j = 0; j < rro_pkg::NPTS; j++) begin
        term_d[n].ta[j] = rro_pkg::XW'(signed'(diff_q[n].py[j]))
                        * rro_pkg::XW'(signed'(diff_q[n].ex));
        term_d[n].tb[j] = rro_pkg::XW'(signed'(diff_q[n].ey))
                        * rro_pkg::XW'(signed'(diff_q[n].px[j]));
      end
    end
  end

  // side signs and edge verdicts; zero counts as non-negative
  always_comb begin
    logic signed [rro_pkg::XW:0] cr;
    logic [rro_pkg::NPTS-1:0]    sd;
    overlap_d = 1'b1;
    for (int n = 0; n < rro_pkg::NEDGE; n++) begin
      for (int j = 0; j < rro_pkg::NPTS; j++) begin
        cr    = (rro_pkg::XW+1)'(signed'(term_q[n].ta[j]))
              - (rro_pkg::XW+1)'(signed'(term_q[n].tb[j]));
        sd[j] = !cr[rro_pkg::XW];
      end
      if (sd[0] == sd[1] && sd[2] == sd[3] && sd[3] == sd[4] && sd[4] == sd[5]
          && sd[0] != sd[2]) begin
        overlap_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      if (en1) valid1_q <= valid_i;
      if (en2) valid2_q <= valid1_q;
      if (en3) valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i)  diff_q    <= diff_d;
    if (en2 && valid1_q) term_q    <= term_d;
    if (en3 && valid2_q) overlap_q <= overlap_d;
  end

  assign valid_o   = valid3_q;
  assign overlap_o = overlap_q;

endmodule

/* src/rotated_rectangle_overlap_test.sv */
// ----------------------------------------------------------------------------
// rotated_rectangle_overlap_test: oriented rectangle overlap, separating edges
// Six-stage pipeline: trig lookup, extent products, corners, differences,
// cross products, side test and verdict.
// ----------------------------------------------------------------------------
// One pair of rectangles per clock enters and one overlap verdict per pair
// leaves, in order, when the output side keeps up. Throughput is one
// transaction per cycle in that case; each of the six register stages
// advances on its own, so bubbles close up behind a stalled output and the
// input keeps accepting until every stage is full. The longest paths are
// the 23x23-bit cross-product multipliers and the extent-by-sine and
// extent-by-cosine multipliers. There is no state besides the pipeline.
module rotated_rectangle_overlap_test (
  input  logic       clk_i,
  input  logic       rst_ni,
  rro_in_if.sink     in_i,
  rro_out_if.source  out_o
);

  rro_pkg::rect_t [1:0] rect;
  rro_pkg::geo_t  [1:0] geo;
  rro_pkg::quad_t [1:0] quad;
  logic                 geo_valid, geo_ready;
  logic                 quad_valid, quad_ready;

  // pack the input transaction
  always_comb begin
    rect[0].cx  = in_i.first_center_x;
    rect[0].cy  = in_i.first_center_y;
    rect[0].w   = in_i.first_width;
    rect[0].h   = in_i.first_height;
    rect[0].ang = in_i.first_angle;
    rect[1].cx  = in_i.second_center_x;
    rect[1].cy  = in_i.second_center_y;
    rect[1].w   = in_i.second_width;
    rect[1].h   = in_i.second_height;
    rect[1].ang = in_i.second_angle;
  end

  rro_sincos u_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .rect_i  (rect),
    .valid_o (geo_valid),
    .ready_i (geo_ready),
    .geo_o   (geo)
  );

  rro_corners u_corners (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (geo_valid),
    .ready_o (geo_ready),
    .geo_i   (geo),
    .valid_o (quad_valid),
    .ready_i (quad_ready),
    .quad_o  (quad)
  );

  rro_sep u_sep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (quad_valid),
    .ready_o   (quad_ready),
    .quad_i    (quad),
    .valid_o   (out_o.valid),
    .ready_i   (out_o.ready),
    .overlap_o (out_o.overlap)
  );

`ifndef NO_ASSERTIONS
  // a free output side means the whole pipe moves
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_o.valid || out_o.ready) |-> in_i.ready)
    else $error("top: input stalled while output side free");

  // degenerate rectangles always overlap, checked while the output side stays ready
  a_zero_extent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.first_width == '0 && in_i.first_height == '0
     && in_i.second_width == '0 && in_i.second_height == '0)
    ##1 out_o.ready ##1 out_o.ready ##1 out_o.ready ##1 out_o.ready ##1 out_o.ready
    |=> (out_o.valid && out_o.overlap))
    else $error("top: zero-extent pair not reported as overlap");
`endif

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: rotated rectangle overlap test
// Drives pairs of rectangles through the valid/ready input channel. It checks
// every overlap verdict, in order, against a hand-written one or a bit-exact
// predictor of the separating-edge test. Both sides idle at random, and once
// the output side holds off long enough to back the pipeline up into the input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 500000;
  localparam int NUM_RANDOM  = 1000;
  localparam int DRAIN_WAIT  = 20;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  logic clk_i;
  logic rst_ni;

  rro_in_if  in_i ();
  rro_out_if out_o ();

  rotated_rectangle_overlap_test uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i.sink),
    .out_o  (out_o.source)
  );

  // directed row: a pair plus an optional hand-written verdict
  typedef struct {
    rro_pkg::rect_t first;
    rro_pkg::rect_t second;
    bit             known;
    bit             verdict;
  } pair_row_t;

  bit     verdict_q[$];
  int     error_count = 0;
  int     accepted_pairs = 0;
  int     cycle_count = 0;
  int     hold_cycles = 0;
  bit     hold_done = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run-away guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // ---- predictor -----------------------------------------------------------

  // Q14 quarter-wave sine at table index q, truncated series as in hardware
  function automatic longint quarter_wave(input longint unsigned q);
    longint unsigned theta, t2, term;
    longint          acc;
    theta = (HALF_PI_Q30 * q) >> (rro_pkg::ANGLE_BITS - 2);
    t2    = (theta * theta) >> 30;
    term  = theta;
    acc   = longint'(theta);
    for (int k = 1; k < 8; k++) begin
      term = (term * t2) >> 30;
      term = term / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc -= longint'(term);
      else            acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 32768) >>> 16;
    if (acc > 16384) acc = 16384;
    return acc;
  endfunction

  function automatic longint sine_of(input logic [rro_pkg::ANGLE_BITS-1:0] a);
    logic [1:0]                     quad;
    logic [rro_pkg::ANGLE_BITS-3:0] r;
    longint                         s;
    quad = a[rro_pkg::ANGLE_BITS-1 -: 2];
    r    = a[rro_pkg::ANGLE_BITS-3:0];
    s    = quad[0] ? quarter_wave((1 << (rro_pkg::ANGLE_BITS - 2)) - r) : quarter_wave(r);
    return quad[1] ? -s : s;
  endfunction

  // corners in Q1, clockwise order of sign pairs
  function automatic void rect_corners(input rro_pkg::rect_t r, output longint px[4],
                                       output longint py[4]);
    longint sn, cs, w, h, dx, dy, ox, oy;
    logic [rro_pkg::ANGLE_BITS-1:0] ca;
    ca = r.ang + rro_pkg::ANGLE_BITS'(1 << (rro_pkg::ANGLE_BITS - 2));
    sn = sine_of(r.ang);
    cs = sine_of(ca);
    w  = r.w;
    h  = r.h;
    for (int i = 0; i < 4; i++) begin
      dx = (i < 2) ? w : -w;
      dy = (i == 0 || i == 3) ? h : -h;
      ox = (dx * cs - dy * sn + 8192) >>> 14;
      oy = (dx * sn + dy * cs + 8192) >>> 14;
      px[i] = 2 * longint'(r.cx) + ox;
      py[i] = 2 * longint'(r.cy) + oy;
    end
  endfunction

  function automatic bit non_negative_side(input longint ax, ay, bx, by, qx, qy);
    return ((qy - ay) * (bx - ax) - (by - ay) * (qx - ax)) >= 0;
  endfunction

  function automatic bit edge_splits(input longint ox[4], oy[4], input int e,
                                     input longint tx[4], ty[4]);
    longint ax, ay, bx, by;
    bit     s1, s2;
    bit     d[4];
    ax = ox[e];             ay = oy[e];
    bx = ox[(e + 1) % 4];   by = oy[(e + 1) % 4];
    s1 = non_negative_side(ax, ay, bx, by, ox[(e + 2) % 4], oy[(e + 2) % 4]);
    s2 = non_negative_side(ax, ay, bx, by, ox[(e + 3) % 4], oy[(e + 3) % 4]);
    for (int i = 0; i < 4; i++) d[i] = non_negative_side(ax, ay, bx, by, tx[i], ty[i]);
    return s1 == s2 && d[0] == d[1] && d[1] == d[2] && d[2] == d[3] && s1 != d[0];
  endfunction

  function automatic bit predict_overlap(input rro_pkg::rect_t a, input rro_pkg::rect_t b);
    longint ax[4], ay[4], bx[4], by[4];
    bit     hit;
    rect_corners(a, ax, ay);
    rect_corners(b, bx, by);
    hit = 1'b1;
    for (int e = 0; e < 4; e++) begin
      if (edge_splits(ax, ay, e, bx, by)) hit = 1'b0;
      if (edge_splits(bx, by, e, ax, ay)) hit = 1'b0;
    end
    return hit;
  endfunction

  // ---- stimulus helpers ----------------------------------------------------

  // mostly back-to-back, sometimes short gaps, rarely long ones
  function automatic int idle_len();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic rro_pkg::rect_t make_rect(input int cx, cy, w, h, ang);
    rro_pkg::rect_t r;
    r.cx  = rro_pkg::COORD_BITS'(cx);
    r.cy  = rro_pkg::COORD_BITS'(cy);
    r.w   = rro_pkg::EXT_BITS'(w);
    r.h   = rro_pkg::EXT_BITS'(h);
    r.ang = rro_pkg::ANGLE_BITS'(ang);
    return r;
  endfunction

  function automatic rro_pkg::rect_t random_rect();
    rro_pkg::rect_t r;
    r.cx  = rro_pkg::COORD_BITS'($urandom);
    r.cy  = rro_pkg::COORD_BITS'($urandom);
    r.w   = rro_pkg::EXT_BITS'($urandom);
    r.h   = rro_pkg::EXT_BITS'($urandom);
    r.ang = rro_pkg::ANGLE_BITS'($urandom);
    return r;
  endfunction

  // second rectangle near the first so that both verdicts are common
  function automatic rro_pkg::rect_t near_rect(input rro_pkg::rect_t a, input int scale);
    rro_pkg::rect_t r;
    r.cx  = a.cx + rro_pkg::COORD_BITS'($urandom_range(4 * scale) - 2 * scale);
    r.cy  = a.cy + rro_pkg::COORD_BITS'($urandom_range(4 * scale) - 2 * scale);
    r.w   = rro_pkg::EXT_BITS'($urandom_range(scale));
    r.h   = rro_pkg::EXT_BITS'($urandom_range(scale));
    r.ang = rro_pkg::ANGLE_BITS'($urandom);
    return r;
  endfunction

  // offer one pair until it is taken, then queue its verdict
  task automatic send_pair(input rro_pkg::rect_t a, input rro_pkg::rect_t b, input bit known,
                           input bit verdict);
    int gap;
    gap = idle_len();
    repeat (gap) begin
      @(negedge clk_i);
      in_i.valid = 1'b0;
    end
    @(negedge clk_i);
    in_i.valid           = 1'b1;
    in_i.first_center_x  = a.cx;
    in_i.first_center_y  = a.cy;
    in_i.first_width     = a.w;
    in_i.first_height    = a.h;
    in_i.first_angle     = a.ang;
    in_i.second_center_x = b.cx;
    in_i.second_center_y = b.cy;
    in_i.second_width    = b.w;
    in_i.second_height   = b.h;
    in_i.second_angle    = b.ang;
    do @(posedge clk_i); while (!in_i.ready);
    verdict_q.insert(verdict_q.size(), known ? verdict : predict_overlap(a, b));
    accepted_pairs++;
  endtask

  // ---- output side: random stalls plus one long hold-off -------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_o.ready <= 1'b0;
    end else if (!hold_done && accepted_pairs >= 40) begin
      hold_done   <= 1'b1;
      hold_cycles <= 300;
      out_o.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_o.ready <= 1'b0;
    end else begin
      out_o.ready <= ($urandom_range(99) < 70);
    end
  end

  // verdict check
  always @(posedge clk_i) begin
    if (rst_ni && out_o.valid && out_o.ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected verdict", out_o.overlap, -1);
      end else begin
        bit want;
        want = verdict_q.pop_front();
        if (out_o.overlap !== want) report_mismatch("overlap", out_o.overlap, want);
      end
    end
  end

  // ---- main sequence -------------------------------------------------------
  initial begin
    pair_row_t      rows[$];
    rro_pkg::rect_t a, b;
    int             mode;
    int             settle;

    rst_ni               = 1'b0;
    in_i.valid           = 1'b0;
    in_i.first_center_x  = '0;
    in_i.first_center_y  = '0;
    in_i.first_width     = '0;
    in_i.first_height    = '0;
    in_i.first_angle     = '0;
    in_i.second_center_x = '0;
    in_i.second_center_y = '0;
    in_i.second_width    = '0;
    in_i.second_height   = '0;
    in_i.second_angle    = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed pairs: zero extents, same box, clear gaps, extremes, edge contact
    rows.insert(rows.size(), '{make_rect(0, 0, 0, 0, 0), make_rect(0, 0, 0, 0, 0), 1, 1});
    rows.insert(rows.size(), '{make_rect(5, -7, 0, 0, 300),
                               make_rect(-900, 40, 0, 0, 77), 1, 1});
    rows.insert(rows.size(), '{make_rect(0, 0, 10, 10, 0), make_rect(0, 0, 10, 10, 0), 1, 1});
    rows.insert(rows.size(), '{make_rect(0, 0, 10, 10, 0),
                               make_rect(100, 0, 10, 10, 0), 1, 0});
    rows.insert(rows.size(), '{make_rect(0, 0, 10, 10, 0),
                               make_rect(0, -100, 10, 10, 256), 1, 0});
    rows.insert(rows.size(), '{make_rect(-524288, -524288, 100, 100, 0),
                               make_rect(524287, 524287, 100, 100, 512), 1, 0});
    rows.insert(rows.size(), '{make_rect(0, 0, 65535, 65535, 0),
                               make_rect(0, 0, 65535, 65535, 1023), 1, 1});
    rows.insert(rows.size(), '{make_rect(524287, -524288, 65535, 0, 1023),
                               make_rect(-524288, 524287, 0, 65535, 768), 0, 0});
    rows.insert(rows.size(), '{make_rect(0, 0, 10, 10, 0),
                               make_rect(20, 0, 10, 10, 0), 0, 0});
    rows.insert(rows.size(), '{make_rect(0, 0, 10, 10, 0),
                               make_rect(20, 20, 10, 10, 0), 0, 0});
    rows.insert(rows.size(), '{make_rect(0, 0, 10, 10, 128),
                               make_rect(28, 0, 10, 10, 0), 0, 0});
    rows.insert(rows.size(), '{make_rect(0, 0, 10, 10, 128),
                               make_rect(24, 0, 10, 10, 128), 0, 0});
    rows.insert(rows.size(), '{make_rect(0, 0, 40, 2, 64),
                               make_rect(0, 30, 2, 40, 960), 0, 0});
    rows.insert(rows.size(), '{make_rect(1, 1, 1, 1, 384),
                               make_rect(2, 2, 1, 1, 640), 0, 0});
    rows.insert(rows.size(), '{make_rect(0, 0, 65535, 1, 896),
                               make_rect(0, 0, 1, 65535, 1), 0, 0});
    foreach (rows[i]) send_pair(rows[i].first, rows[i].second, rows[i].known, rows[i].verdict);

    // random pairs: mostly neighbors of assorted scale, the rest fully random
    for (int n = 0; n < NUM_RANDOM; n++) begin
      mode = $urandom_range(9);
      a = random_rect();
      if (mode < 3) begin
        a.w = rro_pkg::EXT_BITS'($urandom_range(64));
        a.h = rro_pkg::EXT_BITS'($urandom_range(64));
        b = near_rect(a, 64);
      end else if (mode < 6) begin
        a.w = rro_pkg::EXT_BITS'($urandom_range(4000));
        a.h = rro_pkg::EXT_BITS'($urandom_range(4000));
        b = near_rect(a, 4000);
      end else if (mode < 8) begin
        b = near_rect(a, 65535);
      end else begin
        b = random_rect();
      end
      send_pair(a, b, 1'b0, 1'b0);
    end
    @(negedge clk_i);
    in_i.valid = 1'b0;

    // drain, then allow for any stray verdict
    while (verdict_q.size() != 0) @(posedge clk_i);
    settle = 0;
    while (settle < DRAIN_WAIT) begin
      @(posedge clk_i);
      settle++;
    end

    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
src/rro_pkg.sv
src/rro_if.sv
src/rro_sincos.sv
src/rro_corners.sv
src/rro_sep.sv
src/rotated_rectangle_overlap_test.sv
test/testbench.sv
